FILE: design/fcfl_pkg.sv
package fcfl_pkg;

    // Default pool depth
    localparam int MAX_CHUNKS_DEF = 256;

    // Reset value of the chunk count register
    localparam logic [8:0] CHUNK_COUNT_RST = 9'd256;

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Response status codes
    localparam logic [1:0] ST_GRANTED  = 2'd0;
    localparam logic [1:0] ST_FALLBACK = 2'd1;
    localparam logic [1:0] ST_FREED    = 2'd2;
    localparam logic [1:0] ST_PASSED   = 2'd3;

    typedef struct packed {
        logic       kind;
        logic [9:0] free_index;
    } alloc_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] granted_index;
        logic [8:0] free_count;
        logic       pool_empty;
    } alloc_rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture the input beat
        logic exec;     // link store access
        logic finish;   // update list state, load the result register
    } fcfl_cmd_t;

endpackage

FILE: design/fcfl_ctrl.sv
module fcfl_ctrl
    import fcfl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output fcfl_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       finish_go;
    logic       accept;

    // Finish only when the result register is free or being drained
    assign finish_go = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);
    assign in_ready  = (state_reg == S_IDLE) || finish_go;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    assign cmd.load   = accept;
    assign cmd.exec   = (state_reg == S_EXEC);
    assign cmd.finish = finish_go;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (finish_go)
                    state_next = accept ? S_EXEC : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output beat valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish_go)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: design/fcfl_datapath.sv
module fcfl_datapath
    import fcfl_pkg::*;
#(
    parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  fcfl_cmd_t  cmd,
    input  alloc_req_t in_data,
    output alloc_rsp_t out_data,
    input  logic       cfg_we,
    input  logic [8:0] cfg_data
);

    // Indices never exceed 9 bits, so the store needs at most 512 entries
    localparam int         DEPTH    = (MAX_CHUNKS < 512) ? MAX_CHUNKS : 512;
    localparam int         AW       = $clog2(DEPTH);
    localparam int         CAP_I    = (MAX_CHUNKS < 511) ? MAX_CHUNKS : 511;
    localparam int         RST_I    = (CAP_I < 256) ? CAP_I : 256;
    localparam logic [8:0] CAP      = CAP_I[8:0];
    localparam logic [8:0] POOL_RST = RST_I[8:0];
    localparam logic [9:0] DEPTH_W  = DEPTH[9:0];

    logic [8:0]  link_mem [DEPTH];

    logic        kind_reg;
    logic [9:0]  index_reg;
    logic [8:0]  pool_reg;
    logic [8:0]  pool_next;
    logic [8:0]  head_reg;
    logic [8:0]  head_next;
    logic [8:0]  mark_reg;
    logic [8:0]  mark_next;
    logic [8:0]  free_reg;
    logic [8:0]  free_next;
    logic [8:0]  rdata_reg;
    logic        byp_reg;
    alloc_rsp_t  rsp_reg;
    alloc_rsp_t  rsp_next;

    logic        lazy_ok;
    logic        in_pool;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [8:0]  wr_data;
    logic [8:0]  mark_inc;
    logic [8:0]  head_link;

    assign mark_inc = mark_reg + 9'd1;
    assign lazy_ok  = (mark_reg < pool_reg);
    assign in_pool  = (index_reg < {1'b0, pool_reg});
    assign pool_next = (cfg_data > CAP) ? CAP : cfg_data;

    // Input capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= in_data.kind;
            index_reg <= in_data.free_index;
        end
    end

    // Link store write: lazy link on allocate, push on free
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = mark_reg[AW-1:0];
        wr_data = mark_inc;
        if (cmd.exec)
        begin
            if (kind_reg == KIND_ALLOC)
            begin
                wr_en = lazy_ok;
            end
            else
            begin
                wr_en   = in_pool;
                wr_addr = index_reg[AW-1:0];
                wr_data = head_reg;
            end
        end
    end

    // Link store, registered read of the head link
    always_ff @(posedge clk)
    begin
        if (wr_en)
            link_mem[wr_addr] <= wr_data;
        if (cmd.exec && (kind_reg == KIND_ALLOC))
        begin
            rdata_reg <= link_mem[head_reg[AW-1:0]];
            byp_reg   <= lazy_ok && (head_reg == mark_reg);
        end
    end

    // Head link with forwarding of this item's lazy write
    always_comb
    begin
        if ({1'b0, head_reg} >= DEPTH_W)
            head_link = 9'd0;
        else if (byp_reg)
            head_link = mark_inc;
        else
            head_link = rdata_reg;
    end

    // List state update and result
    always_comb
    begin
        head_next = head_reg;
        mark_next = mark_reg;
        free_next = free_reg;
        rsp_next  = rsp_reg;
        if (cmd.finish)
        begin
            rsp_next.granted_index = 8'd0;
            if (kind_reg == KIND_ALLOC)
            begin
                if (lazy_ok)
                    mark_next = mark_inc;
                if (free_reg == 9'd0)
                begin
                    rsp_next.status = ST_FALLBACK;
                end
                else
                begin
                    rsp_next.status        = ST_GRANTED;
                    rsp_next.granted_index = head_reg[7:0];
                    free_next              = free_reg - 9'd1;
                    head_next              = head_link;
                end
            end
            else
            begin
                if (!in_pool)
                begin
                    rsp_next.status = ST_PASSED;
                end
                else
                begin
                    rsp_next.status = ST_FREED;
                    if (free_reg < pool_reg)
                        free_next = free_reg + 9'd1;
                    head_next = index_reg[8:0];
                end
            end
            rsp_next.free_count = free_next;
            rsp_next.pool_empty = (free_next == 9'd0);
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    // Pool control state; a config write reinitializes the pool
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg <= POOL_RST;
            head_reg <= 9'd0;
            mark_reg <= 9'd0;
            free_reg <= POOL_RST;
        end
        else if (cfg_we)
        begin
            pool_reg <= pool_next;
            head_reg <= 9'd0;
            mark_reg <= 9'd0;
            free_reg <= pool_next;
        end
        else
        begin
            head_reg <= head_next;
            mark_reg <= mark_next;
            free_reg <= free_next;
        end
    end

    assign out_data = rsp_reg;

endmodule

FILE: design/fixed_chunk_free_list_allocator.sv
// Each item passes through the exec state (link store read of the head) and
// the finish state (list state update, result register load). A new item is
// accepted only as the last one finishes; finish stalls on an unread result.
// Reset: pool full at 256 chunks (capped at MAX_CHUNKS), list empty of links;
// the link store is not cleared and the block accepts items right after reset.
module fixed_chunk_free_list_allocator
    import fcfl_pkg::*;
#(
    parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  alloc_req_t in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output alloc_rsp_t out_data,
    input  logic       cfg_we,
    input  logic [8:0] cfg_data
);

    fcfl_cmd_t cmd;

    // Sequencer
    fcfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Free list datapath and link store
    fcfl_datapath #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

endmodule
